// ----- src/sha1sh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants of the SHA-1 stream hasher: controller states,
// the command and status groups between controller and datapath, and the
// fixed constants of the hash.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  // Number of chaining words and of digest words.
  localparam int unsigned NUM_CHAIN = 5;
  // Last round of one compression, and the boundaries of the four round groups.
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] GROUP1_START = 7'd20;
  localparam logic [6:0] GROUP2_START = 7'd40;
  localparam logic [6:0] GROUP3_START = 7'd60;
  // Index of the final digest word.
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  // Padding constants.
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;

  // Initial chaining values H0..H4.
  localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round group, selecting the round function and its constant.
  typedef enum logic [1:0] {
    GRP_CH     = 2'd0,
    GRP_PARITY = 2'd1,
    GRP_MAJ    = 2'd2,
    GRP_PAR2   = 2'd3
  } group_t;

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    BSEL_INPUT = 2'd0,
    BSEL_MARK  = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } bsel_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PAD   = 3'd1,
    ST_LOAD  = 3'd2,
    ST_ROUND = 3'd3,
    ST_ADD   = 3'd4,
    ST_EMIT  = 3'd5
  } state_t;

  // Where the controller goes once a compression has finished.
  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_PAD  = 2'd1,
    RET_EMIT = 2'd2
  } ret_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;
    bsel_t      byte_sel;
    logic       count_bits;
    logic       load_vars;
    logic       do_round;
    group_t     group;
    logic       add_chain;
    logic       reinit;
    logic [2:0] emit_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;  // the next byte completes the block
    logic pos_len;   // the next byte lands where the length field starts
  } sts_t;

  // Round constant of a round group.
  function automatic logic [31:0] round_const(input group_t grp);
    logic [31:0] k;
    unique case (grp)
      GRP_CH:     k = 32'h5A827999;
      GRP_PARITY: k = 32'h6ED9EBA1;
      GRP_MAJ:    k = 32'h8F1BBCDC;
      GRP_PAR2:   k = 32'hCA62C1D6;
      default:    k = 32'h5A827999;
    endcase
    return k;
  endfunction

endpackage

// ----- src/sha1_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream with a controller and a one-round-per-cycle
// datapath; emits the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per item carries a message
//   byte (in_data_byte, used when in_byte_present is 1) and an end flag.
//   An end word with no byte closes the message as it stands.
//   Output channel (out_valid / out_stall): after an end word, five words
//   out_digest_word H0..H4 with out_word_index 0..4 and out_last_word on
//   the fifth.
// Timing:
//   Byte words are accepted while the hasher is idle. The 64th byte of a
//   block starts a compression (load, 80 rounds, chaining add), during
//   which in_stall is high.
//   On an end word the padding bytes are written one per cycle (9 to 72),
//   followed by one or two compressions, then the digest words appear.
//   The digest words leave at one per cycle unless out_stall holds them;
//   a stalled word stays put and the input stays stalled until the fifth
//   word is taken, after which the hasher is ready for the next message.
//   Reset (rst_n low, synchronous) loads the initial chaining values and
//   clears the length.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1sh_pkg::cmd_t cmd;
  sha1sh_pkg::sts_t sts;

  // Sequencing of bytes, padding, rounds and digest output.
  sha1sh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .cmd               (cmd),
    .sts               (sts)
  );

  // Schedule, rounds and chaining words.
  sha1sh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

`ifndef SYNTHESIS
  // No new message word is taken while a digest is being handed out.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // The final flag marks the fifth digest word only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word |-> out_word_index == sha1sh_pkg::LAST_WORD_IDX)
    else $error("last word flag on wrong digest word");

  // After the last digest word is taken the output falls silent and input opens.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid && !in_stall)
    else $error("hasher did not return to idle after the digest");

  // Consecutive digest words are numbered in order.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of order");
`endif

endmodule

// ----- src/sha1sh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Controller of the SHA-1 stream hasher. It accepts message words, steps the
// padding sequence, sequences the 80 rounds of each compression and hands
// out the five digest words.
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_byte_present,
  input  logic                in_end_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_word_index,
  output logic                out_last_word,
  output sha1sh_pkg::cmd_t    cmd,
  input  sha1sh_pkg::sts_t    sts
);

  sha1sh_pkg::state_t state_r, state_nxt;
  sha1sh_pkg::ret_t   ret_r, ret_nxt;
  logic               mark_r, mark_nxt;    // the 0x80 marker has been written
  logic               lenph_r, lenph_nxt;  // writing the length field
  logic [6:0]         round_r, round_nxt;
  logic [2:0]         idx_r, idx_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1sh_pkg::ST_IDLE;
      ret_r   <= sha1sh_pkg::RET_IDLE;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
      round_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    mark_nxt  = mark_r;
    lenph_nxt = lenph_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      sha1sh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_present && sts.pos_last) begin
            state_nxt = sha1sh_pkg::ST_LOAD;
            ret_nxt   = in_end_of_message ? sha1sh_pkg::RET_PAD : sha1sh_pkg::RET_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = sha1sh_pkg::ST_PAD;
          end
        end
      end
      sha1sh_pkg::ST_PAD: begin
        if (!mark_r) begin
          mark_nxt = 1'b1;
        end else if (lenph_r || sts.pos_len) begin
          lenph_nxt = 1'b1;
        end
        if (sts.pos_last) begin
          state_nxt = sha1sh_pkg::ST_LOAD;
          ret_nxt   = lenph_nxt ? sha1sh_pkg::RET_EMIT : sha1sh_pkg::RET_PAD;
        end
      end
      sha1sh_pkg::ST_LOAD: begin
        round_nxt = '0;
        state_nxt = sha1sh_pkg::ST_ROUND;
      end
      sha1sh_pkg::ST_ROUND: begin
        round_nxt = round_r + 7'd1;
        if (round_r == sha1sh_pkg::LAST_ROUND) begin
          state_nxt = sha1sh_pkg::ST_ADD;
        end
      end
      sha1sh_pkg::ST_ADD: begin
        unique case (ret_r)
          sha1sh_pkg::RET_IDLE: state_nxt = sha1sh_pkg::ST_IDLE;
          sha1sh_pkg::RET_PAD:  state_nxt = sha1sh_pkg::ST_PAD;
          sha1sh_pkg::RET_EMIT: begin
            state_nxt = sha1sh_pkg::ST_EMIT;
            idx_nxt   = '0;
          end
          default: state_nxt = sha1sh_pkg::ST_IDLE;
        endcase
      end
      sha1sh_pkg::ST_EMIT: begin
        if (!out_stall) begin
          if (idx_r == sha1sh_pkg::LAST_WORD_IDX) begin
            state_nxt = sha1sh_pkg::ST_IDLE;
            mark_nxt  = 1'b0;
            lenph_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = sha1sh_pkg::ST_IDLE;
    endcase
  end

  // Handshakes and datapath commands.
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.byte_sel   = sha1sh_pkg::BSEL_INPUT;
    cmd.emit_idx   = idx_r;
    if (round_r < sha1sh_pkg::GROUP1_START) begin
      cmd.group = sha1sh_pkg::GRP_CH;
    end else if (round_r < sha1sh_pkg::GROUP2_START) begin
      cmd.group = sha1sh_pkg::GRP_PARITY;
    end else if (round_r < sha1sh_pkg::GROUP3_START) begin
      cmd.group = sha1sh_pkg::GRP_MAJ;
    end else begin
      cmd.group = sha1sh_pkg::GRP_PAR2;
    end
    unique case (state_r)
      sha1sh_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.put_byte   = in_valid && in_byte_present;
        cmd.count_bits = in_valid && in_byte_present;
      end
      sha1sh_pkg::ST_PAD: begin
        cmd.put_byte = 1'b1;
        if (!mark_r) begin
          cmd.byte_sel = sha1sh_pkg::BSEL_MARK;
        end else if (lenph_r || sts.pos_len) begin
          cmd.byte_sel = sha1sh_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = sha1sh_pkg::BSEL_ZERO;
        end
      end
      sha1sh_pkg::ST_LOAD:  cmd.load_vars = 1'b1;
      sha1sh_pkg::ST_ROUND: cmd.do_round = 1'b1;
      sha1sh_pkg::ST_ADD:   cmd.add_chain = 1'b1;
      sha1sh_pkg::ST_EMIT: begin
        out_valid  = 1'b1;
        cmd.reinit = !out_stall && (idx_r == sha1sh_pkg::LAST_WORD_IDX);
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == sha1sh_pkg::LAST_WORD_IDX);

endmodule

// ----- src/sha1sh_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_dp
// Datapath of the SHA-1 stream hasher: byte packing into a 16-word schedule
// shift line, the message bit counter, one SHA-1 round per cycle and the
// five chaining words.
// ----------------------------------------------------------------------------
module sha1sh_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_data_byte,
  input  sha1sh_pkg::cmd_t cmd,
  output sha1sh_pkg::sts_t sts,
  output logic [31:0]      out_digest_word
);

  logic [31:0] sched_r [16];          // schedule shift line, oldest word at 0
  logic [23:0] acc_r;                 // bytes of the word being packed
  logic [5:0]  pos_r;                 // byte position in the current block
  logic [63:0] bitlen_r;              // message length in bits
  logic [31:0] chain_r [sha1sh_pkg::NUM_CHAIN];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;

  logic [7:0]  byte_val;
  logic [31:0] f_val;
  logic [31:0] w_new;
  logic [31:0] t_val;

  // Byte to be written into the block.
  always_comb begin
    case (cmd.byte_sel)
      sha1sh_pkg::BSEL_INPUT: byte_val = in_data_byte;
      sha1sh_pkg::BSEL_MARK:  byte_val = sha1sh_pkg::PAD_MARK;
      sha1sh_pkg::BSEL_ZERO:  byte_val = sha1sh_pkg::PAD_ZERO;
      default:                byte_val = bitlen_r[{~pos_r[2:0], 3'b000} +: 8];
    endcase
  end

  // Round function of the current round group.
  always_comb begin
    case (cmd.group)
      sha1sh_pkg::GRP_CH:  f_val = (b_r & (c_r ^ d_r)) ^ d_r;
      sha1sh_pkg::GRP_MAJ: f_val = ((b_r | c_r) & d_r) | (b_r & c_r);
      default:             f_val = b_r ^ c_r ^ d_r;
    endcase
  end

  // Next schedule word and the new working variable a.
  always_comb begin
    w_new = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    w_new = {w_new[30:0], w_new[31]};
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r
          + sha1sh_pkg::round_const(cmd.group) + sched_r[0];
  end

  // Block position, bit counter and chaining words.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      pos_r    <= '0;
      bitlen_r <= '0;
      for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++) begin
        chain_r[i] <= sha1sh_pkg::H_INIT[i];
      end
    end else begin
      if (cmd.put_byte) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.count_bits) begin
        bitlen_r <= bitlen_r + 64'd8;
      end
      if (cmd.add_chain) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
    end
  end

  // Byte packing and schedule shift line.
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      acc_r <= {acc_r[15:0], byte_val};
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          sched_r[i] <= sched_r[i + 1];
        end
        sched_r[15] <= {acc_r, byte_val};
      end
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= w_new;
    end
  end

  // Working variables of the compression.
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.do_round) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign sts.pos_last    = (pos_r == 6'd63);
  assign sts.pos_len     = (pos_r == 6'd56);
  assign out_digest_word = chain_r[cmd.emit_idx];

endmodule

// ----- verif/sha1_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches both channels of the SHA-1 stream hasher. Its own SHA-1 model
// absorbs every accepted byte. At each end of message it queues the five
// digest words it expects, and it compares every accepted output word with
// the oldest one in the queue.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending
);

  localparam logic [31:0] CHAIN_START [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [2:0] FINAL_INDEX = 3'd4;
  localparam logic [5:0] LENGTH_FIELD_POS = 6'd56;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Hash state of the message in progress.
  logic [31:0] chain [5];
  logic [31:0] sched [16];
  logic [63:0] msg_bits;

  digest_word_t expected_digest_words [$];
  int errors = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void start_message();
    for (int i = 0; i < 5; i++) chain[i] = CHAIN_START[i];
    for (int i = 0; i < 16; i++) sched[i] = 32'h0;
    msg_bits = 64'h0;
  endfunction

  // One 80-round compression of the block in sched, added into the chain.
  function automatic void sha1_compress();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rotl(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
                 ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & (c ^ d)) ^ d;
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = ((b | c) & d) | (b & c);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Place a byte big-endian at block position pos; the last slot triggers a compression.
  function automatic void pack_block_byte(input logic [5:0] pos, input logic [7:0] b);
    if (pos[1:0] == 2'd0) sched[pos[5:2]] = 32'h0;
    sched[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
    if (pos == 6'd63) sha1_compress();
  endfunction

  // Pad the message, queue the five digest words and start over.
  function automatic void close_message();
    logic [63:0] len;
    logic [5:0]  pos;
    digest_word_t dw;
    len = msg_bits;
    pos = len[8:3];
    pack_block_byte(pos, 8'h80);
    pos++;
    while (pos != LENGTH_FIELD_POS) begin
      pack_block_byte(pos, 8'h00);
      pos++;
    end
    for (int i = 0; i < 8; i++) begin
      pack_block_byte(pos, len[63 - 8 * i -: 8]);
      pos++;
    end
    for (int i = 0; i < 5; i++) begin
      dw.word = chain[i];
      dw.index = 3'(i);
      dw.last = (3'(i) == FINAL_INDEX);
      expected_digest_words.push_back(dw);
    end
    start_message();
  endfunction

  // Sample both channels at the clock edge; the input side goes first.
  always @(posedge clk) begin
    digest_word_t exp_word;
    if (!rst_n) begin
      start_message();
      expected_digest_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_byte_present) begin
          pack_block_byte(msg_bits[8:3], in_data_byte);
          msg_bits += 64'd8;
        end
        if (in_end_of_message) close_message();
      end
      if (out_valid && !out_stall) begin
        if (expected_digest_words.size() == 0) begin
          $error("unexpected digest word %h (index %0d)", out_digest_word, out_word_index);
          errors++;
        end else begin
          exp_word = expected_digest_words.pop_front();
          if (out_digest_word !== exp_word.word) begin
            $error("digest_word: expected %h, got %h", exp_word.word, out_digest_word);
            errors++;
          end
          if (out_word_index !== exp_word.index) begin
            $error("word_index: expected %0d, got %0d", exp_word.index, out_word_index);
            errors++;
          end
          if (out_last_word !== exp_word.last) begin
            $error("last_word: expected %0b, got %0b", exp_word.last, out_last_word);
            errors++;
          end
        end
      end
    end
    words_pending <= expected_digest_words.size();
    fail_count <= errors;
  end

endmodule

// ----- verif/sha1_stream_hasher_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_test
// Feeds messages byte by byte into the SHA-1 stream hasher. It starts with a
// few directed messages: the empty message, "abc", extreme byte values and
// an ignored word. Short random messages follow, and one message ends near
// the 64-byte block boundary so that its padding needs a second block. The
// sender and receiver idle and stall in several patterns. A separate checker
// predicts and compares the digest words.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int fail_count;
  int words_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int words_offered = 0;
  int cycles = 0;

  sha1_stream_hasher uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_byte_present(in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  sha1_digest_checker digest_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_byte_present(in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index(out_word_index),
    .out_last_word(out_last_word),
    .fail_count(fail_count),
    .words_pending(words_pending)
  );

  always #5 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sha1_stream_hasher");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  int hold_left = 0;
  int holds_started = 0;
  always @(posedge clk) begin
    if (holds_started != holds_requested) begin
      holds_started++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one word after a random idle gap and wait until it is taken.
  task automatic send_word(input logic [7:0] data, input logic present, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_byte_present <= 1'($urandom);
      in_end_of_message <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_present <= present;
    in_end_of_message <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (present || last) words_offered++;
  endtask

  // A message of len random bytes. It is closed either on its last byte or by
  // a separate end word, with an occasional ignored word mixed in.
  task automatic send_message(input int len);
    bit joint;
    joint = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, joint && (i == len - 1));
    end
    if (!joint) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering words until every expected digest word has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    int msgs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an ignored word, the empty message, "abc" closed on its last
    // byte, and the extreme bytes closed by an end word.
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    drain();

    // Random messages under four idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 65;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct = 31;
        end
      endcase

      // In the first pattern the receiver holds off while short messages
      // keep arriving, so the hasher backs up into its input.
      if (ph == 0) begin
        holds_requested++;
        repeat (3) send_message($urandom_range(4));
        drain();
      end

      // Short messages of up to six bytes.
      phase_start = words_offered;
      msgs = 0;
      while ((words_offered - phase_start) < 6 || msgs < 2) begin
        send_message($urandom_range(6));
        msgs++;
      end

      // In the last pattern one message ends near the 64-byte block
      // boundary, so that its padding spills into a second block.
      if (ph == 3) begin
        send_message($urandom_range(64, 56));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("PASS sha1_stream_hasher");
    end else begin
      $display("FAIL sha1_stream_hasher");
    end
    $finish;
  end

endmodule
